/* rtl/lrfr_pkg.sv */
// Shared types, constants and helpers for the LED ribbon frame refresher.
`default_nettype none

package lrfr_pkg;

  // Default frame length in bytes (four LEDs to a byte)
  localparam int FRAME_BYTES_DEF = 17;

  // Configuration port
  localparam int          PADDR_W        = 3;
  localparam logic        REG_INTERVAL   = 1'b0;
  localparam logic [15:0] INTERVAL_RESET = 16'd250;

  // Operation codes of an input word
  typedef enum logic {
    OP_SET  = 1'b0,
    OP_POLL = 1'b1
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SET,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture_set;
    logic update_set;
    logic poll_refresh;
    logic emit_rd;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic set_in_range;
    logic refresh_due;
    logic rd_last;
  } status_t;

  // Colour code remap: the two middle codes swap places
  function automatic logic [1:0] colour_remap(input logic [1:0] code);
    logic [1:0] res;
    case (code)
      2'd1:    res = 2'd2;
      2'd2:    res = 2'd1;
      default: res = code;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/lrfr_ctrl.sv */
// Sequencing state machine of the LED ribbon frame refresher.
`default_nettype none

module lrfr_ctrl
  import lrfr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    operation,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (operation == OP_SET) begin
            if (status.set_in_range) state_next = ST_SET;
          end else if (status.refresh_due) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SET: begin
        state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (status.rd_last) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy             = 1'b0;
        cmd.capture_set  = accept && (operation == OP_SET);
        cmd.poll_refresh = accept && (operation == OP_POLL) && status.refresh_due;
      end
      ST_SET: begin
        cmd.update_set = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_rd = 1'b1;
      end
      ST_FLUSH: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/lrfr_datapath.sv */
// Frame stores, change tracking, refresh timer and byte output of the refresher.
`default_nettype none

module lrfr_datapath
  import lrfr_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output status_t          status,
  input  wire logic [7:0]  led_index,
  input  wire logic [7:0]  colour_code,
  input  wire logic [31:0] time_ms,
  input  wire logic [15:0] refresh_interval_ms,
  output logic [7:0]       frame_byte,
  output logic [4:0]       byte_position,
  output logic             latch_now,
  output logic             result_valid
);

  localparam int              AW        = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [AW-1:0]   LAST_ADDR = AW'(FRAME_BYTES - 1);
  localparam logic [8:0]      LED_LIMIT = 9'(4 * FRAME_BYTES);

  logic [7:0]             pend_mem [FRAME_BYTES];
  logic [7:0]             sent_mem [FRAME_BYTES];
  logic [FRAME_BYTES-1:0] pend_vld;
  logic [FRAME_BYTES-1:0] sent_vld;
  logic [FRAME_BYTES-1:0] diff;

  logic [7:0]    pend_rd;
  logic [7:0]    sent_rd;
  logic          pend_rd_vld;
  logic          sent_rd_vld;
  logic [AW-1:0] pend_raddr;
  logic [AW-1:0] set_addr_in;
  logic [AW-1:0] set_addr;
  logic [1:0]    set_sel;
  logic [1:0]    set_code;
  logic [AW-1:0] rd_cnt;
  logic [AW-1:0] out_idx;
  logic          out_vld;
  logic [31:0]   last_refresh;
  logic [31:0]   elapsed;
  logic [7:0]    pend_old;
  logic [7:0]    sent_old;
  logic [7:0]    set_mask;
  logic [7:0]    set_byte;
  logic [7:0]    out_byte;

  // Address decode of a set word: LED 0 sits in the last byte
  assign set_addr_in         = LAST_ADDR - AW'(led_index[7:2]);
  assign status.set_in_range = {1'b0, led_index} < LED_LIMIT;

  // Refresh decision: any differing byte, or the interval has run out
  assign elapsed            = time_ms - last_refresh;
  assign status.refresh_due = (|diff) || (elapsed >= {16'd0, refresh_interval_ms});
  assign status.rd_last     = rd_cnt == LAST_ADDR;

  assign pend_raddr = cmd.emit_rd ? rd_cnt : set_addr_in;

  // Frame memories, registered reads
  always_ff @(posedge clk) begin
    pend_rd     <= pend_mem[pend_raddr];
    pend_rd_vld <= pend_vld[pend_raddr];
    sent_rd     <= sent_mem[set_addr_in];
    sent_rd_vld <= sent_vld[set_addr_in];
    if (cmd.update_set) pend_mem[set_addr] <= set_byte;
    if (out_vld) sent_mem[out_idx] <= out_byte;
  end

  // Entries never written read as zero
  assign pend_old = pend_rd_vld ? pend_rd : 8'd0;
  assign sent_old = sent_rd_vld ? sent_rd : 8'd0;
  assign out_byte = pend_old;

  // Read-modify-write of one LED's two bits
  assign set_mask = 8'd3 << {set_sel, 1'b0};
  assign set_byte = (pend_old & ~set_mask) | ({6'd0, set_code} << {set_sel, 1'b0});

  // Valid and change bits
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= '0;
      sent_vld <= '0;
      diff     <= '0;
    end else begin
      if (cmd.update_set) begin
        pend_vld[set_addr] <= 1'b1;
        diff[set_addr]     <= set_byte != sent_old;
      end
      if (cmd.poll_refresh) diff <= '0;
      if (out_vld) sent_vld[out_idx] <= 1'b1;
    end
  end

  // Captured set word
  always_ff @(posedge clk) begin
    if (cmd.capture_set) begin
      set_addr <= set_addr_in;
      set_sel  <= led_index[1:0];
      set_code <= colour_remap(colour_code[1:0]);
    end
  end

  // Read counter, output stage and refresh time
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt       <= '0;
      out_vld      <= 1'b0;
      out_idx      <= '0;
      last_refresh <= '0;
    end else begin
      out_vld <= cmd.emit_rd;
      out_idx <= rd_cnt;
      if (cmd.poll_refresh) begin
        rd_cnt       <= '0;
        last_refresh <= time_ms;
      end else if (cmd.emit_rd) begin
        rd_cnt <= rd_cnt + AW'(1);
      end
    end
  end

  assign frame_byte    = out_byte;
  assign byte_position = 5'(out_idx);
  assign latch_now     = out_vld && (out_idx == LAST_ADDR);
  assign result_valid  = out_vld;

endmodule

`default_nettype wire

/* rtl/led_ribbon_frame_refresher_unit.sv */
// Top level of the LED ribbon frame refresher: register port, controller, datapath.
// A set word reads the pending frame memory, then writes the byte back; a quiet poll leaves the block idle.
// A refreshing poll enters the emit state and reads the pending frame through its single read
// port, sending one byte a cycle through a registered output stage, FRAME_BYTES bytes in all;
// busy falls after the flush state, once the last byte is out.
// Reset clears both frames, the refresh time and the interval (250 ms); results cannot stall.
`default_nettype none

module led_ribbon_frame_refresher_unit
  import lrfr_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               operation,
  input  wire logic [7:0]         led_index,
  input  wire logic [7:0]         colour_code,
  input  wire logic [31:0]        time_ms,
  output logic [7:0]              frame_byte,
  output logic [4:0]              byte_position,
  output logic                    latch_now,
  output logic                    result_valid,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [15:0] refresh_interval;
  logic        reg_wr;
  cmd_t        cmd;
  status_t     status;

  // Configuration register
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_interval <= INTERVAL_RESET;
    end else if (reg_wr && (paddr[2] == REG_INTERVAL)) begin
      refresh_interval <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_INTERVAL) ? {16'd0, refresh_interval} : 32'd0;

  lrfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  lrfr_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .led_index           (led_index),
    .colour_code         (colour_code),
    .time_ms             (time_ms),
    .refresh_interval_ms (refresh_interval),
    .frame_byte          (frame_byte),
    .byte_position       (byte_position),
    .latch_now           (latch_now),
    .result_valid        (result_valid)
  );

  // Bytes only leave while a refresh is in progress
  a_word_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result word outside a refresh");

  // A set word never produces output
  a_set_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == OP_SET)) |=> !result_valid)
    else $error("output after a set word");

  // Frame bytes come back to back in order until the latch byte
  a_bytes_in_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !latch_now) |=>
      (result_valid && (byte_position == 5'($past(byte_position) + 5'd1))))
    else $error("frame byte sequence broken");

  // Nothing follows the latch byte
  a_latch_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && latch_now) |=> !result_valid)
    else $error("output after latch byte");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the LED ribbon frame refresher: queued command driver, monitor, predictor.
`default_nettype none

module tb_top
  import lrfr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBYTES         = FRAME_BYTES_DEF;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 20;
  localparam logic [PADDR_W-1:0] INTERVAL_ADDR = PADDR_W'(4 * REG_INTERVAL);
  localparam logic [PADDR_W-1:0] SPARE_ADDR    = PADDR_W'(4 * (REG_INTERVAL + 1));

  typedef struct packed {
    op_t         op;
    logic [7:0]  led;
    logic [7:0]  colour;
    logic [31:0] t;
  } led_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic [4:0] pos;
    logic       latch;
  } frame_out_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  // Block inputs, all known from time zero
  logic               start       = 1'b0;
  logic               operation   = 1'b0;
  logic [7:0]         led_index   = '0;
  logic [7:0]         colour_code = '0;
  logic [31:0]        time_ms     = '0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [31:0]        pwdata      = '0;

  logic        busy;
  logic [7:0]  frame_byte;
  logic [4:0]  byte_position;
  logic        latch_now;
  logic        result_valid;
  logic [31:0] prdata;
  logic        pready;

  led_ribbon_frame_refresher_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .led_index    (led_index),
    .colour_code  (colour_code),
    .time_ms      (time_ms),
    .frame_byte   (frame_byte),
    .byte_position(byte_position),
    .latch_now    (latch_now),
    .result_valid (result_valid),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Pending words, expected frame bytes, bookkeeping
  led_word_t  word_q[$];
  frame_out_t frame_expect[$];
  int unsigned issued_cnt  = 0;
  int unsigned taken_cnt   = 0;
  int unsigned gap_left    = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches  = 0;
  bit          no_idle     = 1'b0;
  logic [31:0] cur_time    = '0;

  // Predictor state
  logic [7:0]  pend_img [NBYTES];
  logic [7:0]  sent_img [NBYTES];
  logic [31:0] last_ms;
  logic [15:0] interval_ms;

  function automatic logic [1:0] swap_colour(input logic [1:0] code);
    logic [1:0] res;
    res = code;
    if (code == 2'd1) res = 2'd2;
    else if (code == 2'd2) res = 2'd1;
    return res;
  endfunction

  // Update the frame images for one word and queue any bytes it sends
  task automatic apply_word(input led_word_t w);
    int         b;
    int         sh;
    bit         differs;
    logic [31:0] elapsed;
    frame_out_t o;
    if (w.op == OP_SET) begin
      if (w.led < 4 * NBYTES) begin
        b = NBYTES - 1 - w.led / 4;
        sh = (w.led % 4) * 2;
        pend_img[b][sh +: 2] = swap_colour(w.colour[1:0]);
      end
    end else begin
      elapsed = w.t - last_ms;
      differs = 1'b0;
      for (int i = 0; i < NBYTES; i++)
        if (pend_img[i] != sent_img[i]) differs = 1'b1;
      if (differs || elapsed >= {16'd0, interval_ms}) begin
        last_ms = w.t;
        for (int i = 0; i < NBYTES; i++) begin
          sent_img[i] = pend_img[i];
          o.data  = pend_img[i];
          o.pos   = 5'(i);
          o.latch = (i == NBYTES - 1);
          frame_expect.push_back(o);
        end
      end
    end
  endtask

  // Driver: next word goes out on the falling edge once the last one was taken
  always @(negedge clk) begin
    led_word_t nxt;
    bit        go;
    go = 1'b0;
    if (!rst && taken_cnt == issued_cnt) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (word_q.size() > 0) begin
        if (!no_idle && $urandom_range(99) < 21) begin
          gap_left = $urandom_range(0, 4);
        end else begin
          nxt = word_q.pop_front();
          go = 1'b1;
        end
      end
      if (go) begin
        operation   <= nxt.op;
        led_index   <= nxt.led;
        colour_code <= nxt.colour;
        time_ms     <= nxt.t;
        issued_cnt++;
      end
      start <= go;
    end
  end

  // Monitor: check result words, feed accepted words and register writes to the predictor
  always @(posedge clk) begin
    frame_out_t exp_out;
    bit         moved;
    moved = 1'b0;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (result_valid) begin
        if (frame_expect.size() == 0) begin
          $error("unexpected result word: frame_byte %0h byte_position %0d", frame_byte,
                 byte_position);
          mismatches++;
        end else begin
          moved = 1'b1;
          exp_out = frame_expect.pop_front();
          if (frame_byte !== exp_out.data) begin
            $error("frame_byte: expected %0h, got %0h", exp_out.data, frame_byte);
            mismatches++;
          end
          if (byte_position !== exp_out.pos) begin
            $error("byte_position: expected %0d, got %0d", exp_out.pos, byte_position);
            mismatches++;
          end
          if (latch_now !== exp_out.latch) begin
            $error("latch_now: expected %0b, got %0b", exp_out.latch, latch_now);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        apply_word('{op_t'(operation), led_index, colour_code, time_ms});
        taken_cnt++;
        moved = 1'b1;
      end
      if (psel && penable && pwrite && pready) begin
        if ((paddr >> 2) == REG_INTERVAL) interval_ms = pwdata[15:0];
        moved = 1'b1;
      end
      // Watchdog on cycles with no progress
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  task automatic push_set(input int idx, input int col);
    word_q.push_back(led_word_t'{OP_SET, 8'(idx), 8'(col), $urandom()});
  endtask

  task automatic push_poll(input logic [31:0] t);
    word_q.push_back(led_word_t'{OP_POLL, 8'($urandom_range(255)), 8'($urandom_range(255)), t});
  endtask

  // Random words: bursts of LED sets and polls with mostly advancing time
  task automatic push_random(input int n);
    int roll;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 55) begin
        if ($urandom_range(99) < 85) push_set($urandom_range(0, 4 * NBYTES - 1),
                                              $urandom_range(255));
        else push_set($urandom_range(255), $urandom_range(255));
      end else begin
        roll = $urandom_range(99);
        if (roll < 10) cur_time = $urandom();
        else if (roll < 18) cur_time = cur_time + $urandom_range(60000, 70000);
        else cur_time = cur_time + $urandom_range(0, 300);
        push_poll(cur_time);
      end
    end
  endtask

  // Wait until every word is taken and every frame byte has come, then let the block settle
  task automatic wait_quiet();
    do @(negedge clk);
    while (word_q.size() != 0 || taken_cnt != issued_cnt || frame_expect.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk);
    while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Sequence of phases
  initial begin
    for (int i = 0; i < NBYTES; i++) begin
      pend_img[i] = '0;
      sent_img[i] = '0;
    end
    last_ms     = '0;
    interval_ms = INTERVAL_RESET;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Directed: packing, ignored indices, interval edges, wrap and time going back
    push_poll(32'd0);
    push_set(0, 8'h01);
    push_set(67, 8'h03);
    push_set(68, 8'h03);
    push_set(255, 8'hFE);
    push_set(1, 8'hFF);
    push_set(2, 8'h02);
    push_set(3, 8'h00);
    push_set(66, 8'h81);
    push_poll(32'd5);
    push_poll(32'd100);
    push_poll(32'd254);
    push_poll(32'd255);
    push_set(0, 8'h05);
    push_poll(32'd300);
    push_poll(32'hFFFF_FFF0);
    push_poll(32'h0000_0010);
    push_poll(32'd5);
    push_set(4, 8'h02);
    push_set(5, 8'h03);
    push_poll(32'd6);
    push_poll(32'd7);
    cur_time = 32'd7;
    wait_quiet();

    // Zero interval: every poll refreshes
    apb_write(INTERVAL_ADDR, 32'd0);
    push_poll(32'd7);
    push_poll(32'd7);
    push_poll(32'd0);
    push_random(30);
    wait_quiet();

    // Widest interval, upper data bits set; unmapped address left alone; no idling
    apb_write(INTERVAL_ADDR, 32'hABCD_FFFF);
    apb_write(SPARE_ADDR, 32'h0000_0000);
    no_idle = 1'b1;
    push_random(40);
    wait_quiet();
    no_idle = 1'b0;

    apb_write(INTERVAL_ADDR, 32'd1);
    push_random(40);
    wait_quiet();

    apb_write(INTERVAL_ADDR, $urandom_range(2, 600));
    push_random(50);
    wait_quiet();

    apb_write(INTERVAL_ADDR, {16'd0, INTERVAL_RESET});
    push_random(25);
    wait_quiet();

    if (mismatches == 0 && frame_expect.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
